// ----- hdl/lmpr_pkg.sv -----
// Package for the learning mesh packet router: field widths, types, register codes.
// No dependencies.
package lmpr_pkg;
    localparam int ADDR_W = 16;
    localparam int HOP_W = 8;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;
    localparam int PORT_W = 2;
    localparam int MASK_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_PORT_COUNT = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TTL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALIVE_MASK = 3'd4;

    localparam logic [KIND_W-1:0] KIND_LOST = 2'd1;

    // table entry: address, port, hops, time
    localparam int ENTRY_W = ADDR_W + PORT_W + HOP_W + TIME_W;

    typedef struct packed {
        logic [ADDR_W-1:0] src_address;
        logic [ADDR_W-1:0] dst_address;
        logic [HOP_W-1:0]  hop_count;
        logic [TIME_W-1:0] arrival_time;
        logic [KIND_W-1:0] payload_kind;
        logic [PORT_W-1:0] arrival_port;
    } t_in_word;

    typedef struct packed {
        logic              deliver_local;
        logic              message_kind;
        logic              forward;
        logic [MASK_W-1:0] egress_ports;
        logic [HOP_W-1:0]  forward_hops;
        logic              table_full;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port;
        logic [HOP_W-1:0]  hops;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0] local_address;
        logic [ADDR_W-1:0] bcast_address;
        logic [HOP_W-1:0]  hop_limit;
        logic [TIME_W-1:0] entry_ttl;
        logic [MASK_W-1:0] port_alive_mask;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC_SCAN,
        ST_LEARN,
        ST_DST_SCAN,
        ST_OUT
    } t_state;
endpackage

// ----- hdl/lmpr_if.sv -----
// Valid/ready channel interface carrying one word of type T.
// No dependencies; the word type comes from the parameter T.
interface lmpr_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/lmpr_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module lmpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                            i_wdata,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- hdl/lmpr_cfg.sv -----
// Configuration register bank.
// Depends on lmpr_pkg.
module lmpr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lmpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lmpr_pkg::t_cfg                  o_cfg
);
    import lmpr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_address     <= '0;
            r_cfg.bcast_address     <= '1;
            r_cfg.hop_limit         <= HOP_W'(8);
            r_cfg.entry_ttl         <= TIME_W'(1000);
            r_cfg.port_alive_mask   <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOCAL_ADDR: r_cfg.local_address     <= i_cfg_data[ADDR_W-1:0];
                REG_BCAST_ADDR: r_cfg.bcast_address     <= i_cfg_data[ADDR_W-1:0];
                REG_HOP_LIMIT:  r_cfg.hop_limit         <= i_cfg_data[HOP_W-1:0];
                REG_ENTRY_TTL:  r_cfg.entry_ttl         <= i_cfg_data[TIME_W-1:0];
                REG_ALIVE_MASK: r_cfg.port_alive_mask   <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ----- hdl/lmpr_ctrl.sv -----
// Sequencer: scans the table memory for the source, learns, then for a forwarded
// unicast scans for the destination; builds the result word. Depends on lmpr_pkg and lmpr_ram.
module lmpr_ctrl #(
    parameter int TABLE_ENTRIES = lmpr_pkg::DEF_TABLE_ENTRIES,
    parameter int PORT_COUNT    = lmpr_pkg::DEF_PORT_COUNT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lmpr_pkg::t_cfg i_cfg,
    lmpr_if.sink           in_ch,
    lmpr_if.source         out_ch
);
    import lmpr_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [MASK_W-1:0] ALL_PORTS =
        (PORT_COUNT >= MASK_W) ? '1 : MASK_W'((1 << PORT_COUNT) - 1);

    t_state r_state, n_state;
    t_in_word r_in;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_rd_idx;
    logic r_rd_live;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    t_entry r_hit_ent, n_hit_ent;
    logic r_full;
    t_out_word r_out;
    logic r_out_valid;

    logic ram_we;
    logic [IDX_W-1:0] ram_addr;
    t_entry ram_wdata, ram_rdata;

    logic [IDX_W-1:0] free_idx;
    logic free_any;
    logic [HOP_W-1:0] inc;
    logic [TIME_W-1:0] age;
    logic rd_ok;
    logic to_local, to_bcast, hop_ok, fwd, deliver;
    logic [MASK_W-1:0] alive, aport_bit, learned_bit;

    lmpr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    assign inc = (r_in.hop_count == '1) ? r_in.hop_count : r_in.hop_count + 1'b1;
    assign age = r_in.arrival_time - r_hit_ent.stamp;
    assign rd_ok = r_rd_live && r_valid[r_rd_idx[IDX_W-1:0]];
    assign to_local = r_in.dst_address == i_cfg.local_address;
    assign to_bcast = r_in.dst_address == i_cfg.bcast_address;
    assign hop_ok = !(inc > i_cfg.hop_limit);
    assign deliver = (to_local || to_bcast) && !r_in.payload_kind[1];
    assign fwd = (to_local || to_bcast)
        ? (deliver && to_bcast && hop_ok && r_in.src_address != i_cfg.local_address)
        : hop_ok;
    assign alive = i_cfg.port_alive_mask & ALL_PORTS;
    assign aport_bit = MASK_W'(1) << r_in.arrival_port;
    assign learned_bit = MASK_W'(1) << r_hit_ent.port;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_hit_ent = r_hit_ent;
        ram_we    = 1'b0;
        ram_addr  = r_idx[IDX_W-1:0];
        ram_wdata = '{address: r_in.src_address, port: r_in.arrival_port,
                      hops: r_in.hop_count, stamp: r_in.arrival_time};
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                n_hit = 1'b0;
                if (in_ch.valid) begin
                    n_state = ST_SRC_SCAN;
                end
            end
            ST_SRC_SCAN: begin
                // address issued by r_idx; data is checked in the next cycle, tagged by r_rd_idx
                if (rd_ok && ram_rdata.address == r_in.src_address && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_rd_idx[IDX_W-1:0];
                    n_hit_ent = ram_rdata;
                end
                if (r_idx != CNT_W'(TABLE_ENTRIES)) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = ST_LEARN;
                end
            end
            ST_LEARN: begin
                if (r_hit) begin
                    ram_addr = r_hit_idx;
                    ram_we = (r_in.hop_count < r_hit_ent.hops) || (age > i_cfg.entry_ttl);
                end else begin
                    ram_addr = free_idx;
                    ram_we = free_any;
                end
                n_idx = '0;
                n_hit = 1'b0;
                n_state = (fwd && !to_bcast) ? ST_DST_SCAN : ST_OUT;
            end
            ST_DST_SCAN: begin
                if (rd_ok && ram_rdata.address == r_in.dst_address && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_ent = ram_rdata;
                end
                if (r_idx != CNT_W'(TABLE_ENTRIES)) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || out_ch.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_rd_live   <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_hit     <= n_hit;
            r_hit_idx <= n_hit_idx;
            r_hit_ent <= n_hit_ent;
            r_rd_idx  <= r_idx;
            r_rd_live <= (r_state == ST_SRC_SCAN || r_state == ST_DST_SCAN)
                         && r_idx <= LAST;
            if (r_state == ST_IDLE && in_ch.valid) begin
                r_in <= in_ch.data;
            end
            if (ram_we) begin
                r_valid[ram_addr] <= 1'b1;
            end
            if (r_state == ST_LEARN) begin
                r_full <= !r_hit && !free_any;
            end
            if (r_state == ST_OUT && (!r_out_valid || out_ch.ready)) begin
                r_out_valid         <= 1'b1;
                r_out.deliver_local <= deliver;
                r_out.message_kind  <= deliver && r_in.payload_kind == KIND_LOST;
                r_out.forward       <= fwd;
                r_out.forward_hops  <= fwd ? inc : '0;
                r_out.table_full    <= r_full;
                if (!fwd) begin
                    r_out.egress_ports <= '0;
                end else if (r_hit && !to_bcast) begin
                    r_out.egress_ports <= learned_bit & alive;
                end else begin
                    r_out.egress_ports <= alive & ~aport_bit;
                end
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign in_ch.ready  = (r_state == ST_IDLE);
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;
endmodule

// ----- hdl/learning_mesh_packet_router.sv -----
// Learning mesh packet router: from acceptance to result a header passes through a source
// scan over the single-port forwarding table memory, the learn write, a destination scan
// of the same table when a unicast header is forwarded, and the result state. One header
// is in flight at a time and the next is taken once its result is registered; the result
// register lets that happen while a result waits. Table valid bits are flip-flops cleared
// by reset.
module learning_mesh_packet_router #(
    parameter int TABLE_ENTRIES = lmpr_pkg::DEF_TABLE_ENTRIES,
    parameter int PORT_COUNT    = lmpr_pkg::DEF_PORT_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lmpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lmpr_if.sink                            in_ch,
    lmpr_if.source                          out_ch
);
    import lmpr_pkg::*;

    t_cfg cfg;

    lmpr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lmpr_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES), .PORT_COUNT(PORT_COUNT)) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    a_fwd_hops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.data.forward |->
            out_ch.data.forward_hops == '0 && out_ch.data.egress_ports == '0)
        else $error("consumed word carries hops or ports");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.data.message_kind |-> out_ch.data.deliver_local)
        else $error("message kind without delivery");
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("second header taken while busy");
`endif
endmodule
